// ===== src/playfair_cipher_engine_top_defines.svh =====
// Assertion macros for the Playfair cipher engine top level.
// Included by playfair_cipher_engine_top.sv; expects clock and reset in scope.
`ifndef PLAYFAIR_CIPHER_ENGINE_TOP_DEFINES_SVH
`define PLAYFAIR_CIPHER_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PFC_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pfc assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PFC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pfc assertion failed");

`endif

// ===== src/pfc_pkg.sv =====
// Shared types, codes and helper functions of the Playfair cipher engine.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

   localparam int unsigned ModeW   = 3;
   localparam int unsigned CharW   = 8;
   localparam int unsigned IdxW    = 5;
   localparam int unsigned LetterW = 7;

   localparam logic [ModeW-1:0] MODE_KEY_LETTER = 3'd0;
   localparam logic [ModeW-1:0] MODE_KEY_FINISH = 3'd1;
   localparam logic [ModeW-1:0] MODE_PLAIN      = 3'd2;
   localparam logic [ModeW-1:0] MODE_CIPHER     = 3'd3;
   localparam logic [ModeW-1:0] MODE_END        = 3'd4;

   localparam logic [IdxW-1:0] IDX_I    = 5'd8;
   localparam logic [IdxW-1:0] IDX_J    = 5'd9;
   localparam logic [IdxW-1:0] IDX_X    = 5'd23;
   localparam logic [IdxW-1:0] IDX_Z    = 5'd25;
   localparam logic [IdxW-1:0] IDX_NONE = 5'd26;

   localparam logic [IdxW-1:0] TABLE_SIZE = 5'd25;
   localparam logic [3:0]      GRID       = 4'd5;

   localparam logic [CharW-1:0] CH_UA = 8'h41;
   localparam logic [CharW-1:0] CH_UZ = 8'h5A;
   localparam logic [CharW-1:0] CH_LA = 8'h61;
   localparam logic [CharW-1:0] CH_LZ = 8'h7A;
   localparam logic [CharW-1:0] CASE_OFFSET = 8'h20;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_POS,
      ST_KEY,
      ST_REJ
   } state_type;

   typedef struct packed {
      logic [LetterW-1:0] letter;
      logic               last;
      logic               status;
   } result_type;

   // Letter index 0..25 with J folded to I, IDX_NONE for a non-letter.
   function automatic logic [IdxW-1:0] letter_index(input logic [CharW-1:0] ch);
      logic [CharW-1:0] c;
      logic [CharW-1:0] v;
      c = ch;
      if (c >= CH_LA && c <= CH_LZ) begin
         c = c - CASE_OFFSET;
      end
      v = c - CH_UA;
      if (c < CH_UA || c > CH_UZ) begin
         return IDX_NONE;
      end else if (v[IdxW-1:0] == IDX_J) begin
         return IDX_I;
      end else begin
         return v[IdxW-1:0];
      end
   endfunction

   // Row of a table slot 0..24: p * 13 / 64 equals p / 5 in that range.
   function automatic logic [2:0] grid_row(input logic [IdxW-1:0] p);
      logic [8:0] m;
      m = {4'd0, p} * 9'd13;
      return m[8:6];
   endfunction

   function automatic logic [2:0] grid_col(input logic [IdxW-1:0] p);
      logic [IdxW-1:0] r5;
      r5 = {2'd0, grid_row(p)} * {1'b0, GRID};
      return 3'(p - r5);
   endfunction

   // Step one place forward (encrypt) or back (decrypt) around the grid.
   function automatic logic [2:0] grid_step(input logic [2:0] c, input logic dec);
      logic [3:0] s;
      s = {1'b0, c} + (dec ? (GRID - 4'd1) : 4'd1);
      if (s >= GRID) begin
         s = s - GRID;
      end
      return s[2:0];
   endfunction

   function automatic logic [IdxW-1:0] grid_slot(input logic [2:0] r, input logic [2:0] c);
      return ({2'd0, r} * {1'b0, GRID}) + {2'd0, c};
   endfunction

endpackage

`default_nettype wire

// ===== src/pfc_if.sv =====
// Request and response channel interfaces of the Playfair cipher engine.
// Depends on pfc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pfc_req_if import pfc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ModeW-1:0] mode;
   logic [CharW-1:0] ch;

   modport source (output valid, output mode, output ch, input ready);
   modport sink (input valid, input mode, input ch, output ready);
endinterface

interface pfc_rsp_if import pfc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LetterW-1:0] letter;
   logic               last;
   logic               status;

   modport source (output valid, output letter, output last, output status, input ready);
   modport sink (input valid, input letter, input last, input status, output ready);
endinterface

`default_nettype wire

// ===== src/playfair_cipher_engine_top.sv =====
// Playfair 5x5 cipher engine: key table build, text preparation and pair ciphering.
// Depends on pfc_pkg, pfc_if and playfair_cipher_engine_top_defines.svh.
//
// Usage:
//  - req_bus carries mode and ch; a request is taken when valid and ready are high.
//  - rsp_bus carries letter, last and status, buffered in a two-entry result queue.
//  - Key letter: no response. Key finish: after the request the engine walks
//    the alphabet one letter a cycle, writing each unused letter other than J into
//    the key memory; no request is taken meanwhile.
//  - A text letter that completes a pair, or an end of message with a held
//    plaintext letter, runs through position memory read, key memory read,
//    then two responses enter the queue. Other text letters and end of message
//    give no response.
//  - Text sent before the key is complete gives one rejection response.
//  - Reset clears the key state and the stream state; the key and position
//    memories hold stale data until a new key is written.
//  - When the receiver stalls, the queue fills and the engine waits in its
//    last step until there is room; requests are held off until then.
`timescale 1ns / 1ps
`default_nettype none
`include "playfair_cipher_engine_top_defines.svh"

module playfair_cipher_engine_top import pfc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pfc_req_if.sink    req_bus,
   pfc_rsp_if.source  rsp_bus
);

   state_type         state_ff, state_in;
   logic [IdxW-1:0]   key_count_ff, key_count_in;
   logic              key_ready_ff, key_ready_in;
   logic [25:0]       used_ff, used_in;
   logic [IdxW-1:0]   prev_ff, prev_in;
   logic              prev_valid_ff, prev_valid_in;
   logic [IdxW-1:0]   held_ff, held_in;
   logic              held_valid_ff, held_valid_in;
   logic              dir_ff, dir_in;
   logic              dec_ff, dec_in;
   logic [IdxW-1:0]   fill_x_ff, fill_x_in;

   logic [IdxW-1:0]   key_mem [25];
   logic [IdxW-1:0]   pos_mem [26];
   logic [IdxW-1:0]   pos_a_ff, pos_b_ff;
   logic [IdxW-1:0]   kt_a_ff, kt_b_ff;

   logic              kt_we, pos_we, kt_re, pos_re;
   logic [IdxW-1:0]   kt_waddr, kt_wdata, pos_waddr, pos_wdata;
   logic [IdxW-1:0]   kt_raddr_a, kt_raddr_b, pos_raddr_a, pos_raddr_b;

   result_type        out_mem [2];
   logic              out_wr_ff, out_wr_in;
   logic              out_rd_ff, out_rd_in;
   logic [1:0]        out_count_ff, out_count_in;
   logic [1:0]        push_n;
   logic [1:0]        out_free;
   result_type        res0, res1;

   logic              accept, pop, dec, held_e, prev_e;
   logic [IdxW-1:0]   v;
   logic [IdxW-1:0]   base_count;
   logic [25:0]       base_used;
   logic [2:0]        r1, c1, r2, c2;

   assign accept         = req_bus.valid && req_bus.ready;
   assign pop            = rsp_bus.valid && rsp_bus.ready;
   assign v              = letter_index(req_bus.ch);
   assign dec            = (req_bus.mode == MODE_CIPHER);
   assign held_e         = held_valid_ff && (dir_ff == dec);
   assign prev_e         = prev_valid_ff && (dir_ff == dec);
   assign base_count     = key_ready_ff ? '0 : key_count_ff;
   assign base_used      = key_ready_ff ? '0 : used_ff;
   assign out_free       = 2'd2 - out_count_ff + {1'b0, pop};
   assign r1             = grid_row(pos_a_ff);
   assign c1             = grid_col(pos_a_ff);
   assign r2             = grid_row(pos_b_ff);
   assign c2             = grid_col(pos_b_ff);

   assign req_bus.ready  = (state_ff == ST_IDLE);
   assign rsp_bus.valid  = (out_count_ff != 2'd0);
   assign rsp_bus.letter = out_mem[out_rd_ff].letter;
   assign rsp_bus.last   = out_mem[out_rd_ff].last;
   assign rsp_bus.status = out_mem[out_rd_ff].status;

   always_comb begin
      state_in      = state_ff;
      key_count_in  = key_count_ff;
      key_ready_in  = key_ready_ff;
      used_in       = used_ff;
      prev_in       = prev_ff;
      prev_valid_in = prev_valid_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      dir_in        = dir_ff;
      dec_in        = dec_ff;
      fill_x_in     = fill_x_ff;
      kt_we         = 1'b0;
      kt_waddr      = key_count_ff;
      kt_wdata      = v;
      pos_we        = 1'b0;
      pos_waddr     = v;
      pos_wdata     = key_count_ff;
      pos_re        = 1'b0;
      pos_raddr_a   = held_ff;
      pos_raddr_b   = v;
      kt_re         = 1'b0;
      kt_raddr_a    = '0;
      kt_raddr_b    = '0;
      push_n        = 2'd0;
      res0          = '{letter: {2'd0, kt_a_ff} + CH_UA[LetterW-1:0], last: 1'b0,
                        status: 1'b0};
      res1          = '{letter: {2'd0, kt_b_ff} + CH_UA[LetterW-1:0], last: 1'b1,
                        status: 1'b0};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_bus.mode)
                  MODE_KEY_LETTER: begin
                     if (key_ready_ff) begin
                        key_ready_in  = 1'b0;
                        held_in       = '0;
                        held_valid_in = 1'b0;
                        prev_in       = '0;
                        prev_valid_in = 1'b0;
                     end
                     used_in      = base_used;
                     key_count_in = base_count;
                     if (v != IDX_NONE && !base_used[v] && base_count < TABLE_SIZE) begin
                        kt_we        = 1'b1;
                        kt_waddr     = base_count;
                        pos_we       = 1'b1;
                        pos_wdata    = base_count;
                        used_in[v]   = 1'b1;
                        key_count_in = base_count + 5'd1;
                     end
                  end
                  MODE_KEY_FINISH: begin
                     fill_x_in = '0;
                     state_in  = ST_FILL;
                  end
                  MODE_PLAIN, MODE_CIPHER: begin
                     if (!key_ready_ff) begin
                        state_in = ST_REJ;
                     end else if (v != IDX_NONE) begin
                        dir_in = dec;
                        dec_in = dec;
                        if (dir_ff != dec) begin
                           held_in       = '0;
                           held_valid_in = 1'b0;
                           prev_in       = '0;
                           prev_valid_in = 1'b0;
                        end
                        if (!dec && prev_e && prev_ff == v) begin
                           prev_in       = v;
                           prev_valid_in = 1'b1;
                           pos_re        = 1'b1;
                           state_in      = ST_POS;
                           if (held_e) begin
                              pos_raddr_a   = held_ff;
                              pos_raddr_b   = IDX_X;
                              held_in       = v;
                              held_valid_in = 1'b1;
                           end else begin
                              pos_raddr_a   = IDX_X;
                              pos_raddr_b   = v;
                              held_in       = IDX_X;
                              held_valid_in = 1'b0;
                           end
                        end else begin
                           if (!dec) begin
                              prev_in       = v;
                              prev_valid_in = 1'b1;
                           end
                           if (held_e) begin
                              pos_re        = 1'b1;
                              pos_raddr_a   = held_ff;
                              pos_raddr_b   = v;
                              held_valid_in = 1'b0;
                              state_in      = ST_POS;
                           end else begin
                              held_in       = v;
                              held_valid_in = 1'b1;
                           end
                        end
                     end
                  end
                  MODE_END: begin
                     if (held_valid_ff && !dir_ff && key_ready_ff) begin
                        pos_re      = 1'b1;
                        pos_raddr_a = held_ff;
                        pos_raddr_b = IDX_X;
                        dec_in      = 1'b0;
                        state_in    = ST_POS;
                     end
                     held_in       = '0;
                     held_valid_in = 1'b0;
                     prev_in       = '0;
                     prev_valid_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FILL: begin
            if (fill_x_ff != IDX_J && !used_ff[fill_x_ff] && key_count_ff < TABLE_SIZE) begin
               kt_we                = 1'b1;
               kt_waddr             = key_count_ff;
               kt_wdata             = fill_x_ff;
               pos_we               = 1'b1;
               pos_waddr            = fill_x_ff;
               pos_wdata            = key_count_ff;
               used_in[fill_x_ff]   = 1'b1;
               key_count_in         = key_count_ff + 5'd1;
            end
            if (fill_x_ff == IDX_Z) begin
               key_ready_in  = 1'b1;
               held_in       = '0;
               held_valid_in = 1'b0;
               prev_in       = '0;
               prev_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end else begin
               fill_x_in = fill_x_ff + 5'd1;
            end
         end
         ST_POS: begin
            kt_re = 1'b1;
            if (r1 == r2) begin
               kt_raddr_a = grid_slot(r1, grid_step(c1, dec_ff));
               kt_raddr_b = grid_slot(r2, grid_step(c2, dec_ff));
            end else if (c1 == c2) begin
               kt_raddr_a = grid_slot(grid_step(r1, dec_ff), c1);
               kt_raddr_b = grid_slot(grid_step(r2, dec_ff), c2);
            end else begin
               kt_raddr_a = grid_slot(r1, c2);
               kt_raddr_b = grid_slot(r2, c1);
            end
            state_in = ST_KEY;
         end
         ST_KEY: begin
            if (out_free == 2'd2) begin
               push_n   = 2'd2;
               state_in = ST_IDLE;
            end
         end
         ST_REJ: begin
            res0 = '{letter: '0, last: 1'b1, status: 1'b1};
            if (out_free != 2'd0) begin
               push_n   = 2'd1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign out_wr_in    = out_wr_ff ^ push_n[0];
   assign out_rd_in    = out_rd_ff ^ pop;
   assign out_count_in = out_count_ff + push_n - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         key_count_ff  <= '0;
         key_ready_ff  <= 1'b0;
         used_ff       <= '0;
         prev_ff       <= '0;
         prev_valid_ff <= 1'b0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         dir_ff        <= 1'b0;
         dec_ff        <= 1'b0;
         fill_x_ff     <= '0;
         out_wr_ff     <= 1'b0;
         out_rd_ff     <= 1'b0;
         out_count_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         key_count_ff  <= key_count_in;
         key_ready_ff  <= key_ready_in;
         used_ff       <= used_in;
         prev_ff       <= prev_in;
         prev_valid_ff <= prev_valid_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         dir_ff        <= dir_in;
         dec_ff        <= dec_in;
         fill_x_ff     <= fill_x_in;
         out_wr_ff     <= out_wr_in;
         out_rd_ff     <= out_rd_in;
         out_count_ff  <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (kt_we) begin
         key_mem[kt_waddr] <= kt_wdata;
      end
      if (kt_re) begin
         kt_a_ff <= key_mem[kt_raddr_a];
         kt_b_ff <= key_mem[kt_raddr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[pos_waddr] <= pos_wdata;
      end
      if (pos_re) begin
         pos_a_ff <= pos_mem[pos_raddr_a];
         pos_b_ff <= pos_mem[pos_raddr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         out_mem[out_wr_ff] <= res0;
      end
      if (push_n == 2'd2) begin
         out_mem[~out_wr_ff] <= res1;
      end
   end

   `PFC_ASSERT_IMPLY(a_ready_full_key, key_ready_ff, key_count_ff == TABLE_SIZE)
   `PFC_ASSERT_IMPLY(a_queue_bound, 1'b1, out_count_ff <= 2'd2)
   `PFC_ASSERT_IMPLY(a_reject_form, rsp_bus.valid && rsp_bus.status, rsp_bus.letter == '0 && rsp_bus.last)
   `PFC_ASSERT_NEXT(a_finish_fills, accept && req_bus.mode == MODE_KEY_FINISH, state_ff == ST_FILL)

endmodule

`default_nettype wire
